// ===== design/ofc_pkg.sv =====
// Package for the orientation face classifier: widths, register codes,
// the face direction table and the fixed-point helper functions.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ofc_pkg;

   localparam int FACE_COUNT_DEF     = 9;
   localparam int COMP_FRAC_BITS_DEF = 14;
   localparam int IN_FRAC_BITS       = 14;
   localparam int TABLE_FACES        = 9;
   localparam int AXES               = 3;
   localparam int GROUP_SIZE         = 3;
   localparam int NUM_GROUPS         = TABLE_FACES / GROUP_SIZE;

   localparam int GRAV_W     = 16;
   localparam int TIME_W     = 32;
   localparam int CFG_W      = 16;
   localparam int FACE_IDX_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;

   // Pipeline: input, products, scores, group minima, face, result.
   localparam int PIPE_DEPTH = 6;

   localparam logic [CFG_W-1:0] HOLD_TIME_RESET      = 16'd2000;
   localparam logic [CFG_W-1:0] CHECK_INTERVAL_RESET = 16'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOLD_TIME      = 1'b0,
      REG_CHECK_INTERVAL = 1'b1
   } reg_index_type;

   // Load enables for the classification stages.
   typedef struct packed {
      logic ld_prod;
      logic ld_score;
      logic ld_group;
      logic ld_face;
   } pipe_ctl_type;

   // Face directions in hundredths of 1 g.
   localparam int FACE_HUNDREDTHS [TABLE_FACES][AXES] = '{
      '{ 100,   0,   0 },
      '{ -40,   3,  91 },
      '{ -38,  92,  -2 },
      '{ -37,   2, -93 },
      '{ -40, -92,  -3 },
      '{  32,   1,  95 },
      '{  32,  95,  -1 },
      '{  32,   1, -95 },
      '{  32, -95,  -1 }
   };

   // Hundredths to fixed point, halves rounded away from zero.
   function automatic longint face_fixed(input int h, input int frac);
      longint s;
      longint m;
      s = longint'(1) << frac;
      m = (h >= 0) ? longint'(h) : -longint'(h);
      m = (m * s + 50) / 100;
      return (h >= 0) ? m : -m;
   endfunction

   // Squared length of one face vector in fixed point.
   function automatic longint face_sq(input int f, input int frac);
      longint acc;
      longint c;
      acc = 0;
      for (int a = 0; a < AXES; a++) begin
         c   = face_fixed(FACE_HUNDREDTHS[f][a], frac);
         acc = acc + c * c;
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== design/ofc_if.sv =====
// Valid/ready channel interfaces for sample requests and results.
// Depends on ofc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ofc_req_if;
   import ofc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GRAV_W-1:0] grav_x;
   logic signed [GRAV_W-1:0] grav_y;
   logic signed [GRAV_W-1:0] grav_z;
   logic [TIME_W-1:0]        now_ms;

   modport source (output valid, grav_x, grav_y, grav_z, now_ms, input ready);
   modport sink   (input valid, grav_x, grav_y, grav_z, now_ms, output ready);
endinterface

interface ofc_rsp_if;
   import ofc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  evaluated;
   logic [FACE_IDX_W-1:0] face_index;
   logic                  face_confirmed;

   modport source (output valid, evaluated, face_index, face_confirmed, input ready);
   modport sink   (input valid, evaluated, face_index, face_confirmed, output ready);
endinterface

`default_nettype wire

// ===== design/ofc_nearest.sv =====
// Nearest face search: per-face dot products, scores, grouped minimum.
// Depends on ofc_pkg; stage enables come from the top level.
`timescale 1ns / 1ps
`default_nettype none

module ofc_nearest #(
   parameter int FACE_COUNT     = ofc_pkg::FACE_COUNT_DEF,
   parameter int COMP_FRAC_BITS = ofc_pkg::COMP_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire ofc_pkg::pipe_ctl_type            ctl,
   input  wire logic signed [ofc_pkg::GRAV_W-1:0] grav_x,
   input  wire logic signed [ofc_pkg::GRAV_W-1:0] grav_y,
   input  wire logic signed [ofc_pkg::GRAV_W-1:0] grav_z,
   output logic [ofc_pkg::FACE_IDX_W-1:0]        face_index
);
   import ofc_pkg::*;

   localparam int UP = (COMP_FRAC_BITS >= IN_FRAC_BITS) ? COMP_FRAC_BITS - IN_FRAC_BITS : 0;
   localparam int DN = (COMP_FRAC_BITS <  IN_FRAC_BITS) ? IN_FRAC_BITS - COMP_FRAC_BITS : 0;
   localparam int GW = GRAV_W + UP;
   localparam int FW = COMP_FRAC_BITS + 2;
   localparam int PW = GW + FW;
   localparam int SW = PW + 4;
   localparam int NC = (FACE_COUNT < TABLE_FACES) ? FACE_COUNT : TABLE_FACES;

   logic signed [GRAV_W-1:0] grav   [AXES];
   logic signed [GW-1:0]     g_comp [AXES];
   logic signed [FW-1:0]     coef   [TABLE_FACES][AXES];
   logic signed [SW-1:0]     fsq    [TABLE_FACES];

   logic signed [PW-1:0]     prod_ff  [TABLE_FACES][AXES];
   logic signed [SW-1:0]     score_ff [TABLE_FACES];

   logic                     grp_valid_in [NUM_GROUPS];
   logic [FACE_IDX_W-1:0]    grp_idx_in   [NUM_GROUPS];
   logic signed [SW-1:0]     grp_score_in [NUM_GROUPS];
   logic                     grp_valid_ff [NUM_GROUPS];
   logic [FACE_IDX_W-1:0]    grp_idx_ff   [NUM_GROUPS];
   logic signed [SW-1:0]     grp_score_ff [NUM_GROUPS];

   logic [FACE_IDX_W-1:0]    face_in;
   logic [FACE_IDX_W-1:0]    face_ff;

   assign grav[0] = grav_x;
   assign grav[1] = grav_y;
   assign grav[2] = grav_z;

   // Move the sample to the comparison scale; the downward move floors.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         g_comp[a] = (GW'(grav[a]) <<< UP) >>> DN;
      end
   end

   for (genvar f = 0; f < TABLE_FACES; f++) begin : g_face
      assign fsq[f] = SW'(face_sq(f, COMP_FRAC_BITS));
      for (genvar a = 0; a < AXES; a++) begin : g_axis
         assign coef[f][a] = FW'(face_fixed(FACE_HUNDREDTHS[f][a], COMP_FRAC_BITS));
      end
   end

   // The common |g|^2 term is dropped: score = |f|^2 - 2 g.f orders the
   // faces exactly as the squared distance does.
   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         for (int f = 0; f < TABLE_FACES; f++) begin
            for (int a = 0; a < AXES; a++) begin
               prod_ff[f][a] <= PW'(g_comp[a]) * PW'(coef[f][a]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_score) begin
         for (int f = 0; f < TABLE_FACES; f++) begin
            score_ff[f] <= fsq[f]
                         - ((SW'(prod_ff[f][0]) + SW'(prod_ff[f][1]) + SW'(prod_ff[f][2])) <<< 1);
         end
      end
   end

   // Minimum within each group of three; strict compare keeps the lower index.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_valid_in[g] = 1'b0;
         grp_idx_in[g]   = '0;
         grp_score_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if ((g * GROUP_SIZE + k) < NC) begin
               if (!grp_valid_in[g] || (score_ff[g * GROUP_SIZE + k] < grp_score_in[g])) begin
                  grp_valid_in[g] = 1'b1;
                  grp_idx_in[g]   = FACE_IDX_W'(g * GROUP_SIZE + k);
                  grp_score_in[g] = score_ff[g * GROUP_SIZE + k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_group) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_valid_ff[g] <= grp_valid_in[g];
            grp_idx_ff[g]   <= grp_idx_in[g];
            grp_score_ff[g] <= grp_score_in[g];
         end
      end
   end

   // Group 0 always covers face 0, so it is always valid and seeds the final pick.
   always_comb begin
      logic signed [SW-1:0] best;
      best    = grp_score_ff[0];
      face_in = grp_idx_ff[0];
      for (int g = 1; g < NUM_GROUPS; g++) begin
         if (grp_valid_ff[g] && (grp_score_ff[g] < best)) begin
            best    = grp_score_ff[g];
            face_in = grp_idx_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_face) begin
         face_ff <= face_in;
      end
   end

   assign face_index = face_ff;

endmodule

`default_nettype wire

// ===== design/orientation_face_classifier.sv =====
// Orientation face classifier. Throughput is one sample per cycle through
// six register stages while results are taken; a full, stalled output
// register still lets empty earlier stages take new samples.
// Synchronous active-high reset clears the stage valid bits, resets the
// debounce state and loads the two registers (hold time 2000 ms, check
// interval 500 ms).
`timescale 1ns / 1ps
`default_nettype none

module orientation_face_classifier #(
   parameter int FACE_COUNT     = ofc_pkg::FACE_COUNT_DEF,
   parameter int COMP_FRAC_BITS = ofc_pkg::COMP_FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ofc_req_if.sink                              req,
   ofc_rsp_if.source                            rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ofc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ofc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ofc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import ofc_pkg::*;

   // Wide enough to hold FACE_COUNT, which is the "no face" marker.
   localparam int SFW  = $clog2(FACE_COUNT + 1);
   localparam int LAST = PIPE_DEPTH - 1;

   // ------------------------------------------------------------------
   // Configuration registers. The register index is address bit 2, so
   // every byte address of the port lands on one of the two registers.
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] hold_ff;
   logic [CFG_W-1:0] interval_ff;
   logic             csr_write;
   reg_index_type    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= HOLD_TIME_RESET;
         interval_ff <= CHECK_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HOLD_TIME:      hold_ff     <= csr_pwdata[CFG_W-1:0];
            REG_CHECK_INTERVAL: interval_ff <= csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_HOLD_TIME:      csr_prdata = CSR_DATA_W'(hold_ff);
         REG_CHECK_INTERVAL: csr_prdata = CSR_DATA_W'(interval_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Stage flow control. Each stage takes new data when it is empty or
   // when the stage after it is ready, so bubbles are squeezed out and
   // a stalled result does not block the empty stages in front of it.
   // Stage 0 is the input register and the last stage is the result.
   // ------------------------------------------------------------------
   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_src;
   logic [LAST:0] rdy;
   logic [LAST:0] load;
   pipe_ctl_type  ctl;

   always_comb begin
      rdy[LAST] = !valid_ff[LAST] || rsp.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i + 1];
      end
      valid_src[0] = req.valid;
      for (int i = 1; i <= LAST; i++) begin
         valid_src[i] = valid_ff[i - 1];
      end
      load = rdy & valid_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i <= LAST; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_src[i];
            end
         end
      end
   end

   assign req.ready    = rdy[0];
   assign ctl.ld_prod  = load[1];
   assign ctl.ld_score = load[2];
   assign ctl.ld_group = load[3];
   assign ctl.ld_face  = load[4];

   // ------------------------------------------------------------------
   // Input register, and the sample time carried alongside the search.
   // ------------------------------------------------------------------
   logic signed [GRAV_W-1:0] gx_ff;
   logic signed [GRAV_W-1:0] gy_ff;
   logic signed [GRAV_W-1:0] gz_ff;
   logic [TIME_W-1:0]        now_ff [LAST];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         gx_ff     <= req.grav_x;
         gy_ff     <= req.grav_y;
         gz_ff     <= req.grav_z;
         now_ff[0] <= req.now_ms;
      end
      for (int i = 1; i < LAST; i++) begin
         if (load[i]) begin
            now_ff[i] <= now_ff[i - 1];
         end
      end
   end

   // The nearest-face search covers stages 1 through 4.
   logic [FACE_IDX_W-1:0] face;

   ofc_nearest #(
      .FACE_COUNT     (FACE_COUNT),
      .COMP_FRAC_BITS (COMP_FRAC_BITS)
   ) u_nearest (
      .clock      (clock),
      .ctl        (ctl),
      .grav_x     (gx_ff),
      .grav_y     (gy_ff),
      .grav_z     (gz_ff),
      .face_index (face)
   );

   // ------------------------------------------------------------------
   // Result stage: check interval, debounce and the state update. All of
   // the state lives here, so samples update it strictly in order and
   // the next sample always sees what the previous one left behind.
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] check_time_ff;
   logic [TIME_W-1:0] seen_since_ff;
   logic [SFW-1:0]    seen_face_ff;
   logic [SFW-1:0]    stable_face_ff;
   logic              evaluated_ff;
   logic [FACE_IDX_W-1:0] face_out_ff;
   logic              confirmed_ff;

   logic [TIME_W-1:0] now_last;
   logic [SFW-1:0]    face_s;
   logic              eval_in;
   logic              new_seen;
   logic              confirm_in;

   assign now_last = now_ff[LAST - 1];
   assign face_s   = SFW'(face);

   // Both time tests are plain unsigned compares against a wrapped difference.
   always_comb begin
      eval_in    = !(check_time_ff > (now_last - TIME_W'(interval_ff)));
      new_seen   = eval_in && (seen_face_ff != face_s);
      confirm_in = eval_in && !new_seen && (stable_face_ff != face_s)
                   && (seen_since_ff <= (now_last - TIME_W'(hold_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_time_ff  <= '0;
         seen_since_ff  <= '0;
         seen_face_ff   <= SFW'(FACE_COUNT);
         stable_face_ff <= SFW'(FACE_COUNT);
      end else if (load[LAST]) begin
         if (eval_in) begin
            check_time_ff <= now_last;
         end
         if (new_seen) begin
            seen_face_ff  <= face_s;
            seen_since_ff <= now_last;
         end
         if (confirm_in) begin
            stable_face_ff <= face_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[LAST]) begin
         evaluated_ff <= eval_in;
         face_out_ff  <= eval_in ? face : '0;
         confirmed_ff <= confirm_in;
      end
   end

   assign rsp.valid          = valid_ff[LAST];
   assign rsp.evaluated      = evaluated_ff;
   assign rsp.face_index     = face_out_ff;
   assign rsp.face_confirmed = confirmed_ff;

`ifndef NO_ASSERTIONS
   // A skipped sample reports no face and no confirmation.
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.evaluated) |-> (rsp.face_index == '0 && !rsp.face_confirmed))
      else $error("skipped sample carries a face or a confirmation");

   // A confirmation leaves the confirmed face equal to the face last seen.
   a_confirm_state: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.face_confirmed) |->
         (stable_face_ff == seen_face_ff && SFW'(rsp.face_index) == stable_face_ff))
      else $error("confirmation does not match the debounce state");

   // Only defined faces below the face count can come out of the search.
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.face_index < FACE_IDX_W'(TABLE_FACES)
                     && 32'(rsp.face_index) < 32'(FACE_COUNT)))
      else $error("face index out of range");

   // A stalled result keeps its place until it is transferred.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(face_out_ff)))
      else $error("stalled result was dropped or changed");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_orientation_face_classifier.sv =====
// Self-checking testbench for the orientation face classifier: sample and
// result channels with random idling, register writes over the CSR port.
// Depends on ofc_pkg, ofc_if and the orientation_face_classifier RTL.
`timescale 1ns / 1ps

typedef struct packed {
   logic                           evaluated;
   logic [ofc_pkg::FACE_IDX_W-1:0] face_index;
   logic                           face_confirmed;
} face_result_type;

// Tracks the classifier state and the results still owed by the block.
class face_tracker;
   int              face_total;
   int              frac_bits;
   longint          face_pt [9][3];
   logic [15:0]     hold_ms;
   logic [15:0]     interval_ms;
   logic [3:0]      seen_face;
   logic [3:0]      stable_face;
   logic [31:0]     seen_since;
   logic [31:0]     check_time;
   face_result_type pending_q [$];
   int              mismatches;

   function new(int faces, int frac);
      int     cent [9][3] = '{
         '{ 100,   0,   0 }, '{ -40,   3,  91 }, '{ -38,  92,  -2 },
         '{ -37,   2, -93 }, '{ -40, -92,  -3 }, '{  32,   1,  95 },
         '{  32,  95,  -1 }, '{  32,   1, -95 }, '{  32, -95,  -1 }
      };
      longint mag;
      face_total = faces;
      frac_bits  = frac;
      // Hundredths to fixed point, halves rounded away from zero.
      for (int f = 0; f < 9; f++) begin
         for (int a = 0; a < 3; a++) begin
            mag = (cent[f][a] < 0) ? -longint'(cent[f][a]) : longint'(cent[f][a]);
            mag = (mag * (longint'(1) << frac) + 50) / 100;
            face_pt[f][a] = (cent[f][a] < 0) ? -mag : mag;
         end
      end
      hold_ms     = ofc_pkg::HOLD_TIME_RESET;
      interval_ms = ofc_pkg::CHECK_INTERVAL_RESET;
      seen_face   = 4'(faces);
      stable_face = 4'(faces);
      seen_since  = '0;
      check_time  = '0;
      mismatches  = 0;
   endfunction

   function void log_failure(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch: %s", $realtime, msg);
   endfunction

   // Q2.14 input moved to the comparison precision; a down shift floors.
   function longint to_comp(logic signed [15:0] v);
      longint x;
      x = longint'(v);
      if (frac_bits >= ofc_pkg::IN_FRAC_BITS)
         return x <<< (frac_bits - ofc_pkg::IN_FRAC_BITS);
      return x >>> (ofc_pkg::IN_FRAC_BITS - frac_bits);
   endfunction

   function face_result_type take_sample(logic signed [15:0] gx, logic signed [15:0] gy,
                                         logic signed [15:0] gz, logic [31:0] now);
      face_result_type r;
      longint          g [3];
      longint          d;
      longint          best_d;
      longint          diff;
      logic [3:0]      best;
      logic [31:0]     due;
      r   = '0;
      due = now - interval_ms;
      if (check_time > due) begin
         pending_q.push_back(r);
         return r;
      end
      check_time = now;
      g[0] = to_comp(gx);
      g[1] = to_comp(gy);
      g[2] = to_comp(gz);
      best   = '0;
      best_d = 0;
      for (int f = 0; f < face_total && f < 9; f++) begin
         d = 0;
         for (int a = 0; a < 3; a++) begin
            diff = g[a] - face_pt[f][a];
            d    = d + diff * diff;
         end
         if (f == 0 || d < best_d) begin
            best   = 4'(f);
            best_d = d;
         end
      end
      // Debounce: a new face restarts the hold, a held one gets confirmed.
      due = now - hold_ms;
      if (seen_face != best) begin
         seen_face  = best;
         seen_since = now;
      end else if (stable_face != best && seen_since <= due) begin
         stable_face      = best;
         r.face_confirmed = 1'b1;
      end
      r.evaluated  = 1'b1;
      r.face_index = best;
      pending_q.push_back(r);
      return r;
   endfunction

   function void compare_result(logic ev, logic [3:0] idx, logic conf);
      face_result_type want;
      if (pending_q.size() == 0) begin
         log_failure($sformatf("result with nothing outstanding: evaluated %0b face %0d confirmed %0b",
                               ev, idx, conf));
         return;
      end
      want = pending_q.pop_front();
      if (ev !== want.evaluated)
         log_failure($sformatf("evaluated expected %0b, got %0b", want.evaluated, ev));
      if (idx !== want.face_index)
         log_failure($sformatf("face_index expected %0d, got %0d", want.face_index, idx));
      if (conf !== want.face_confirmed)
         log_failure($sformatf("face_confirmed expected %0b, got %0b", want.face_confirmed, conf));
   endfunction
endclass

module tb_orientation_face_classifier;
   import ofc_pkg::*;

   localparam int FACES       = 9;
   localparam int FRAC        = 14;
   localparam int RUN_ITEMS   = 1100;
   localparam int PHASES      = 7;
   localparam int CYCLE_LIMIT = 600_000;
   localparam int SPREAD      = 2500;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ofc_req_if req_ch ();
   ofc_rsp_if rsp_ch ();

   orientation_face_classifier #(
      .FACE_COUNT     (FACES),
      .COMP_FRAC_BITS (FRAC)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock with a 20 ns period.
   always #10 clock = ~clock;

   face_tracker tracker;

   // When steady is set, neither side inserts idle cycles, so the block
   // also sees long stretches of back-to-back transfers.
   logic        steady = 1'b0;
   int          cycles = 0;
   logic [31:0] stamp;
   int          skip_run;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int pick;
      if (steady)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      if (pick < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[orientation_face_classifier] ERROR");
         $finish;
      end
   end

   // Results are sampled at the rising edge; the flops of the block update
   // in the same step only after this process has read their old values.
   always @(posedge clock) begin
      if (!reset && tracker != null && rsp_ch.valid && rsp_ch.ready)
         tracker.compare_result(rsp_ch.evaluated, rsp_ch.face_index, rsp_ch.face_confirmed);
   end

   // Result side back-pressure: ready drops for random stretches.
   initial begin : rsp_backpressure
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
               stall_left = idle_len();
         end
      end
   end

   // One CSR access: setup cycle, then access cycle until pready. Entered and
   // left at a falling edge.
   task automatic csr_access(input reg_index_type r, input logic wr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = CSR_ADDR_W'(r) << 2;
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Writes a register, reads it back and hands the new value to the tracker.
   task automatic set_register(input reg_index_type r, input logic [15:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(r, 1'b1, CSR_DATA_W'(value), rd);
      csr_access(r, 1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(value))
         tracker.log_failure($sformatf("register %s read back %0d, wrote %0d",
                                       r.name(), rd, value));
      case (r)
         REG_HOLD_TIME: begin
            tracker.hold_ms = value;
         end
         REG_CHECK_INTERVAL: begin
            tracker.interval_ms = value;
         end
         default: begin
         end
      endcase
   endtask

   // Offers one sample after a random gap and waits for its transfer. Valid
   // stays high across back-to-back samples; it only drops for a gap.
   task automatic send_sample(input logic signed [15:0] gx, input logic signed [15:0] gy,
                              input logic signed [15:0] gz, input logic [31:0] now);
      int              gap;
      face_result_type r;
      gap = idle_len();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.grav_x = gx;
      req_ch.grav_y = gy;
      req_ch.grav_z = gz;
      req_ch.now_ms = now;
      do @(posedge clock); while (!req_ch.ready);
      r        = tracker.take_sample(gx, gy, gz, now);
      skip_run = r.evaluated ? 0 : skip_run + 1;
      @(negedge clock);
   endtask

   task automatic send_face(input int f, input logic [31:0] now);
      send_sample(16'(tracker.face_pt[f][0]), 16'(tracker.face_pt[f][1]),
                  16'(tracker.face_pt[f][2]), now);
   endtask

   // Withdraws the sample offer at once, so nothing is taken twice, then
   // waits until every transfer owed by the block has arrived, and returns
   // at a falling edge.
   task automatic drain();
      req_ch.valid = 1'b0;
      while (tracker.pending_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
      @(negedge clock);
   endtask

   // A component scattered around a face vector, clipped to the input range.
   function automatic logic signed [15:0] scatter(input longint centre);
      longint v;
      v = centre + longint'($urandom_range(0, 2 * SPREAD)) - SPREAD;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return 16'(v);
   endfunction

   // Times mostly step forward by up to the check interval plus a quarter
   // of the hold time plus 50; a few jump anywhere or near the wrap point.
   // After many skipped samples the time goes to the next due time plus up
   // to the hold time, else a jump backward would stall evaluation for long.
   task automatic next_stamp();
      int span;
      int pick;
      span = int'(tracker.interval_ms) + int'(tracker.hold_ms) / 4 + 50;
      pick = $urandom_range(0, 99);
      if (skip_run > 12)
         stamp = tracker.check_time + tracker.interval_ms + $urandom_range(0, tracker.hold_ms);
      else if (pick < 3)
         stamp = $urandom();
      else if (pick < 5)
         stamp = 32'hFFFF_FFFF - $urandom_range(0, span);
      else
         stamp = stamp + $urandom_range(0, span);
   endtask

   // Random phase: runs of samples that dwell on one face, so the debounce
   // gets to confirm faces, broken by samples of other faces and by noise.
   task automatic run_phase(input int count);
      int                 sent;
      int                 run_len;
      int                 target;
      int                 f;
      int                 pick;
      logic signed [15:0] g [3];
      sent = 0;
      while (sent < count) begin
         target  = $urandom_range(0, FACES - 1);
         run_len = $urandom_range(2, 14);
         if ($urandom_range(0, 6) == 0)
            steady = ~steady;
         for (int i = 0; i < run_len && sent < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               for (int a = 0; a < 3; a++)
                  g[a] = 16'($urandom());
            end else begin
               f = (pick < 14) ? $urandom_range(0, FACES - 1) : target;
               for (int a = 0; a < 3; a++)
                  g[a] = scatter(tracker.face_pt[f][a]);
            end
            next_stamp();
            send_sample(g[0], g[1], g[2], stamp);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int          hold_plan [PHASES] = '{0, 65535, 100, 0, 1, 65535, 2000};
      int          ivl_plan  [PHASES] = '{0, 65535, 10, 0, 65535, 0, 500};
      logic [15:0] hold_val;
      logic [15:0] ivl_val;

      tracker       = new(FACES, FRAC);
      skip_run      = 0;
      stamp         = '0;
      req_ch.valid  = 1'b0;
      req_ch.grav_x = '0;
      req_ch.grav_y = '0;
      req_ch.grav_z = '0;
      req_ch.now_ms = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;

      // Reset is held from time zero and released at a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples with the reset register values. The very first
      // sample at time zero must be evaluated because the timer comparison
      // wraps. A face seen again later than the hold time gets confirmed,
      // a sample inside the check interval is skipped.
      send_sample(16'sd16384, 16'sd0, 16'sd0, 32'd0);
      send_face(1, 32'd10_000);
      send_face(1, 32'd10_100);
      send_face(1, 32'd10_500);
      send_face(1, 32'd12_000);
      send_face(1, 32'd12_600);
      for (int f = 2; f < FACES; f++)
         send_face(f, 32'd13_200 + 32'(600 * f));
      // Corners of the input range and the zero vector.
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd20_000);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd20_600);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 32'd21_200);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd21_800);
      send_sample(16'sh0000, 16'sh0000, 16'sh0000, 32'd22_400);
      // Time wrap: the hold and the check interval straddle 2^32.
      send_face(5, 32'hFFFF_F000);
      send_face(5, 32'hFFFF_FE00);
      send_face(5, 32'h0000_0100);
      send_face(5, 32'h0000_0150);
      stamp = 32'h0000_0150;

      // Random phases, each under its own pair of register values. The
      // registers only change once the block has drained.
      for (int p = 0; p < PHASES; p++) begin
         hold_val = 16'(hold_plan[p]);
         ivl_val  = 16'(ivl_plan[p]);
         if (p == 3) begin
            hold_val = 16'($urandom_range(0, 65535));
            ivl_val  = 16'($urandom_range(0, 65535));
         end
         drain();
         set_register(REG_HOLD_TIME, hold_val);
         set_register(REG_CHECK_INTERVAL, ivl_val);
         steady = ($urandom_range(0, 3) == 0);
         run_phase(RUN_ITEMS / PHASES);
      end

      drain();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_q.size() == 0)
         $display("[orientation_face_classifier] OK");
      else
         $display("[orientation_face_classifier] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/ofc_pkg.sv
design/ofc_if.sv
design/ofc_nearest.sv
design/orientation_face_classifier.sv
bench/tb_orientation_face_classifier.sv
